// ===== src/selectable_key_hash_unit_assert.svh =====
// assertion macros shared by the hash unit rtl
`ifndef SELECTABLE_KEY_HASH_UNIT_ASSERT_SVH
`define SELECTABLE_KEY_HASH_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SKH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define SKH_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/skh_pkg.sv =====
package skh_pkg;

	// hash scheme codes
	typedef enum logic [1:0] {
		KIND_MULT_TOP = 2'd0,
		KIND_MULT_LOW = 2'd1,
		KIND_TAB      = 2'd2,
		KIND_FMIX     = 2'd3
	} hash_kind_t;

	// request codes
	typedef enum logic {
		REQ_HASH  = 1'b0,
		REQ_WRITE = 1'b1
	} req_type_t;

	// register index, decoded from one address bit
	typedef enum logic {
		REG_HASH_KIND = 1'b0,
		REG_HASH_BITS = 1'b1
	} reg_idx_t;

	localparam int PADDR_W     = 3;
	localparam int REG_SEL_BIT = 2;
	localparam int APB_DATA_W  = 32;
	localparam int BITS_W      = 6;
	localparam int KEY_W       = 64;
	localparam int HASH_W      = 32;
	localparam int NUM_TABLES  = 8;
	localparam int BYTE_W      = 8;
	localparam int TABLE_DEPTH = 256;
	localparam int SEL_W       = 3;
	localparam int FMIX_SHIFT  = 33;

	localparam logic [BITS_W-1:0] HASH_BITS_RESET = 6'd32;
	localparam logic [BITS_W-1:0] HASH_BITS_MAX   = 6'd32;

	localparam logic [KEY_W-1:0] MULT_MAGIC = 64'd21742483383879;
	localparam logic [KEY_W-1:0] FMIX_C1    = 64'hff51_afd7_ed55_8ccd;
	localparam logic [KEY_W-1:0] FMIX_C2    = 64'hc4ce_b9fe_1a85_ec53;

	// live configuration
	typedef struct packed {
		hash_kind_t              kind;
		logic [BITS_W-1:0]       bits;
	} cfg_t;

	// stage enables of the split multiplier
	typedef struct packed {
		logic en_a;
		logic en_b;
	} mul_ctl_t;

	// table read, xor and write strobes
	typedef struct packed {
		logic rd_en;
		logic xor_en;
		logic wr_en;
	} tab_ctl_t;

endpackage

// ===== src/skh_if.sv =====
// request channel: hash a key or write one table word
interface skh_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [63:0] key;
	logic [2:0]  table_select;
	logic [7:0]  entry_index;
	logic [31:0] entry_value;

	modport source (
		output valid, req_type, key, table_select, entry_index, entry_value,
		input  ready
	);
	modport sink (
		input  valid, req_type, key, table_select, entry_index, entry_value,
		output ready
	);
endinterface

// result channel: one hash word per hash request
interface skh_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] hash_value;

	modport source (
		output valid, hash_value,
		input  ready
	);
	modport sink (
		input  valid, hash_value,
		output ready
	);
endinterface

// ===== src/skh_cfg.sv =====
module skh_cfg
	import skh_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	hash_kind_t        kind_q;
	logic [BITS_W-1:0] bits_q;
	logic              wr;
	reg_idx_t          idx;

	assign wr     = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[REG_SEL_BIT]);
	assign pready = 1'b1;

	// register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_MULT_TOP;
			bits_q <= HASH_BITS_RESET;
		end else if (wr) begin
			unique case (idx)
				REG_HASH_KIND: kind_q <= hash_kind_t'(pwdata[1:0]);
				REG_HASH_BITS: bits_q <= pwdata[BITS_W-1:0];
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (idx)
			REG_HASH_KIND: prdata = APB_DATA_W'(kind_q);
			REG_HASH_BITS: prdata = APB_DATA_W'(bits_q);
		endcase
	end

	assign cfg.kind = kind_q;
	assign cfg.bits = bits_q;

endmodule

// ===== src/skh_tab.sv =====
module skh_tab
	import skh_pkg::*;
#(
	parameter int ENTRY_BITS = 32
) (
	input  logic                  clk,
	input  tab_ctl_t              ctl,
	input  logic [KEY_W-1:0]      key,
	input  logic [SEL_W-1:0]      wr_sel,
	input  logic [BYTE_W-1:0]     wr_idx,
	input  logic [ENTRY_BITS-1:0] wr_data,
	output logic [HASH_W-1:0]     tab_value
);

	logic [ENTRY_BITS-1:0] rd_s1 [NUM_TABLES];
	logic [ENTRY_BITS-1:0] xor_d;
	logic [ENTRY_BITS-1:0] xor_s2;

	// one byte table per key byte, one write and one read port each
	for (genvar t = 0; t < NUM_TABLES; t++) begin : g_tab
		logic [ENTRY_BITS-1:0] mem [TABLE_DEPTH];

		always_ff @(posedge clk) begin
			if (ctl.wr_en && wr_sel == SEL_W'(t))
				mem[wr_idx] <= wr_data;
			if (ctl.rd_en)
				rd_s1[t] <= mem[key[BYTE_W*t +: BYTE_W]];
		end
	end

	// fold the eight words
	always_comb begin
		xor_d = '0;
		for (int t = 0; t < NUM_TABLES; t++)
			xor_d ^= rd_s1[t];
	end

	always_ff @(posedge clk) begin
		if (ctl.xor_en)
			xor_s2 <= xor_d;
	end

	assign tab_value = HASH_W'(xor_s2);

endmodule

// ===== src/skh_mul64.sv =====
// low 64 bits of a 64 x 64 product, from three 32 x 32 partials
module skh_mul64
	import skh_pkg::*;
(
	input  logic             clk,
	input  mul_ctl_t         ctl,
	input  logic [KEY_W-1:0] a,
	input  logic [KEY_W-1:0] b,
	output logic [KEY_W-1:0] prod
);

	logic [63:0] pl_d;
	logic [31:0] pa_d;
	logic [31:0] pb_d;
	logic [63:0] pl_s1;
	logic [31:0] pa_s1;
	logic [31:0] pb_s1;
	logic [31:0] hi_sum;
	logic [63:0] prod_s2;

	// partial products; the high x high term falls off the top
	assign pl_d = {32'b0, a[31:0]} * {32'b0, b[31:0]};
	assign pa_d = a[63:32] * b[31:0];
	assign pb_d = a[31:0] * b[63:32];

	always_ff @(posedge clk) begin
		if (ctl.en_a) begin
			pl_s1 <= pl_d;
			pa_s1 <= pa_d;
			pb_s1 <= pb_d;
		end
	end

	// combine into the upper word
	assign hi_sum = pa_s1 + pb_s1;

	always_ff @(posedge clk) begin
		if (ctl.en_b)
			prod_s2 <= pl_s1 + {hi_sum, 32'b0};
	end

	assign prod = prod_s2;

endmodule

// ===== src/selectable_key_hash_unit.sv =====
// selectable key hash unit: five-stage pipeline, one request accepted per cycle unless rsp stalls
// a hash beat passes stages s1 to s5 in turn and is shown on rsp from the s5 register
// throughput: one item per cycle unless rsp stalls; the two-stage multipliers in series set the latency
// table writes land in the byte tables at the accepting edge and give no result
// reset: arst_n clears the valid bits and the registers to hash_kind 0, hash_bits 32;
// table contents are undefined until written
`include "selectable_key_hash_unit_assert.svh"

module selectable_key_hash_unit
	import skh_pkg::*;
#(
	parameter int TABLE_ENTRY_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	skh_req_if.sink               req,
	skh_rsp_if.source             rsp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	cfg_t              cfg;
	tab_ctl_t          tab_ctl;
	mul_ctl_t          m1_ctl;
	mul_ctl_t          m2_ctl;
	logic              en_s1, en_s2, en_s3, en_s4, en_s5;
	logic              v_s1, v_s2, v_s3, v_s4, v_s5;
	logic              acc;
	logic [KEY_W-1:0]  x1;
	logic [KEY_W-1:0]  m1_b;
	logic [KEY_W-1:0]  p1;
	logic [KEY_W-1:0]  x2;
	logic [KEY_W-1:0]  p2;
	logic [KEY_W-1:0]  f3;
	logic [HASH_W-1:0] tab_value;
	logic [BITS_W-1:0] bits_sat;
	logic [32:0]       mask;
	logic [HASH_W-1:0] res_d;
	logic [HASH_W-1:0] res_s3;
	logic [HASH_W-1:0] res_s4;
	logic [HASH_W-1:0] hash_s5;

	// configuration registers
	skh_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// stage enables: a stage moves when empty or when the next one moves
	assign en_s5 = !v_s5 || rsp.ready;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign req.ready = en_s1;
	assign acc = req.valid && en_s1;

	// valid bits; table writes stop at the entry stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= req.valid && (req.req_type == REQ_HASH);
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	// byte tables: write and read at the accepting edge
	assign tab_ctl.rd_en  = en_s1;
	assign tab_ctl.xor_en = en_s2;
	assign tab_ctl.wr_en  = acc && (req.req_type == REQ_WRITE);

	skh_tab #(
		.ENTRY_BITS (TABLE_ENTRY_BITS)
	) u_tab (
		.clk       (clk),
		.ctl       (tab_ctl),
		.key       (req.key),
		.wr_sel    (req.table_select),
		.wr_idx    (req.entry_index),
		.wr_data   (req.entry_value[TABLE_ENTRY_BITS-1:0]),
		.tab_value (tab_value)
	);

	// first multiply: key times the magic, or the first fmix round
	assign x1   = (cfg.kind == KIND_FMIX) ? (req.key ^ (req.key >> FMIX_SHIFT)) : req.key;
	assign m1_b = (cfg.kind == KIND_FMIX) ? FMIX_C1 : MULT_MAGIC;
	assign m1_ctl.en_a = en_s1;
	assign m1_ctl.en_b = en_s2;

	skh_mul64 u_mul1 (
		.clk  (clk),
		.ctl  (m1_ctl),
		.a    (x1),
		.b    (m1_b),
		.prod (p1)
	);

	// second fmix round
	assign x2 = p1 ^ (p1 >> FMIX_SHIFT);
	assign m2_ctl.en_a = en_s3;
	assign m2_ctl.en_b = en_s4;

	skh_mul64 u_mul2 (
		.clk  (clk),
		.ctl  (m2_ctl),
		.a    (x2),
		.b    (FMIX_C2),
		.prod (p2)
	);

	// multiplicative bit selection and tabulation pick
	always_comb begin
		bits_sat = (cfg.bits > HASH_BITS_MAX) ? HASH_BITS_MAX : cfg.bits;
		mask     = (33'd1 << bits_sat) - 33'd1;
		case (cfg.kind)
			KIND_MULT_TOP: res_d = (bits_sat == '0) ? '0
				: (p1[63:32] >> (HASH_BITS_MAX - bits_sat));
			KIND_MULT_LOW: res_d = p1[31:0] & mask[31:0];
			KIND_TAB:      res_d = tab_value;
			default:       res_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s3) res_s3 <= res_d;
		if (en_s4) res_s4 <= res_s3;
	end

	// output register, last fmix fold
	assign f3 = p2 ^ (p2 >> FMIX_SHIFT);

	always_ff @(posedge clk) begin
		if (en_s5)
			hash_s5 <= (cfg.kind == KIND_FMIX) ? f3[HASH_W-1:0] : res_s4;
	end

	assign rsp.valid      = v_s5;
	assign rsp.hash_value = hash_s5;

	// pipeline checks
	`SKH_ASSERT_NXT(a_write_no_beat, clk, arst_n,
		req.valid && req.ready && (req.req_type == REQ_WRITE), !v_s1,
		"table write entered the hash pipeline")
	`SKH_ASSERT_NXT(a_hash_enters, clk, arst_n,
		req.valid && req.ready && (req.req_type == REQ_HASH), v_s1,
		"accepted hash request lost at entry")
	`SKH_ASSERT_NXT(a_s4_holds, clk, arst_n,
		v_s4 && !en_s4, v_s4 && $stable(res_s4),
		"stalled stage four changed")
	`SKH_ASSERT_NXT(a_s4_to_out, clk, arst_n,
		v_s4 && en_s5, rsp.valid,
		"stage four beat did not reach the output")

endmodule
